// ----- sv/altitude_vario_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the altitude vario filter unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_VARIO_FILTER_UNIT_MACROS_SVH
`define ALTITUDE_VARIO_FILTER_UNIT_MACROS_SVH

// holds at every clock edge out of reset
`define AVF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now, consequent in the following cycle
`define AVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/avf_pkg.sv -----
// ----------------------------------------------------------------------------
// avf_pkg
// Widths, register codes and divider handoff types for the vario filter.
// ----------------------------------------------------------------------------
package avf_pkg;

  localparam int ALT_W      = 23;  // altitude sample width
  localparam int RATE_W     = 16;  // climb / vario width
  localparam int SENS_W     = 3;
  localparam int SPAN_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int CNT_W      = 5;   // holds any window length up to 30
  localparam int DVS_W      = 5;   // divisor width
  localparam int DIV_W      = 27;  // sum of up to ten 23-bit samples

  localparam int DEF_ALT_TAPS           = 10;
  localparam int DEF_VARIO_SLOTS        = 24;
  localparam int DEF_SAMPLES_PER_SECOND = 8;
  localparam int DEF_LONG_SLOTS         = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_VARIO_SENS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_SPAN = 1'b1;

  localparam logic [SENS_W-1:0] SENS_RST = 3'd3;
  localparam logic [SPAN_W-1:0] SPAN_RST = 2'd1;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } avf_div_req_t;

  typedef struct packed {
    logic                    done;
    logic                    busy;
    logic signed [DIV_W-1:0] quotient;
  } avf_div_rsp_t;

endpackage

// ----- sv/avf_div.sv -----
// ----------------------------------------------------------------------------
// avf_div
// Shared signed divider, restoring, one quotient bit per cycle, truncates
// toward zero.
// ----------------------------------------------------------------------------
module avf_div import avf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  avf_div_req_t req_i,
  output avf_div_rsp_t rsp_o
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] num_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;
  logic [DIV_W-1:0] mag_in;

  always_comb begin
    rem_sh  = {rem_q, num_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    mag_in  = req_i.dividend[DIV_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.dividend[DIV_W-1];
        num_q  <= mag_in;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        cnt_q  <= '0;
      end else if (busy_q) begin
        // quotient bits shift in as dividend bits shift out
        num_q <= {num_q[DIV_W-2:0], fits};
        rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o.done     = done_q;
    rsp_o.busy     = busy_q;
    rsp_o.quotient = neg_q ? $signed(~num_q + 1'b1) : $signed(num_q);
  end

endmodule

// ----- sv/altitude_vario_filter_unit.sv -----
// ----------------------------------------------------------------------------
// altitude_vario_filter_unit
// Altitude moving average, climb rate, vario rate and long climb average.
// ----------------------------------------------------------------------------
// One raw altitude word in on in_valid_i/in_ready_o, one result word out on
// out_valid_o/out_ready_i. cfg_we_i writes the vario window setting (index 0)
// or the long window span (index 1); write only while no word is in flight.
// A sequencer walks each window through one accumulator and hands every sum
// to one shared bit-serial divider. Every word runs the altitude window, the
// climb step and the vario window of vn entries; a sample that closes a
// second also runs the one-second ring and the long window of ln entries,
// where vn = 4*sensitivity capped at VARIO_SLOTS (12 at defaults) and
// ln = 10*span capped at LONG_SLOTS. The sums take one entry per cycle.
// in_ready_o is high only while the sequencer is idle. A finished result sits
// in the output register; the next word may be accepted while it waits, and
// the sequencer holds its following result until the receiver takes it.
// Reset clears all windows and rings to zero, arms first-sample handling and
// loads the register defaults (sensitivity 3, span 1).
// ----------------------------------------------------------------------------
`include "altitude_vario_filter_unit_macros.svh"

module altitude_vario_filter_unit import avf_pkg::*; #(
  parameter int ALT_TAPS           = DEF_ALT_TAPS,
  parameter int VARIO_SLOTS        = DEF_VARIO_SLOTS,
  parameter int SAMPLES_PER_SECOND = DEF_SAMPLES_PER_SECOND,
  parameter int LONG_SLOTS         = DEF_LONG_SLOTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ALT_W-1:0] altitude_cm_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ALT_W-1:0]  filtered_altitude_cm_o,
  output logic signed [RATE_W-1:0] instant_climb_o,
  output logic signed [RATE_W-1:0] vario_rate_o,
  output logic signed [RATE_W-1:0] long_climb_o,
  output logic                     average_updated_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = (ALT_TAPS > 1) ? $clog2(ALT_TAPS) : 1;
  localparam int VW = $clog2(VARIO_SLOTS);
  localparam int SW = $clog2(SAMPLES_PER_SECOND);
  localparam int LW = $clog2(LONG_SLOTS);

  localparam logic signed [DIV_W-1:0] SAT_HI = DIV_W'(32767);
  localparam logic signed [DIV_W-1:0] SAT_LO = -DIV_W'(32768);

  typedef enum logic [3:0] {
    S_IDLE, S_ALT_SUM, S_ALT_DIV, S_CLIMB, S_VAR_SUM, S_VAR_DIV,
    S_SEC_SUM, S_SEC_DIV, S_LONG_SUM, S_LONG_DIV, S_DONE
  } state_e;

  state_e state_q;

  logic [SENS_W-1:0] sens_q;
  logic [SPAN_W-1:0] span_q;

  logic signed [ALT_W-1:0]  win_q   [ALT_TAPS];
  logic signed [RATE_W-1:0] vring_q [VARIO_SLOTS];
  logic signed [RATE_W-1:0] sring_q [SAMPLES_PER_SECOND];
  logic signed [RATE_W-1:0] lring_q [LONG_SLOTS];
  logic [VW-1:0] vslot_q;
  logic [SW-1:0] sslot_q;
  logic [LW-1:0] lslot_q;

  logic signed [ALT_W-1:0]  raw_q;
  logic signed [ALT_W-1:0]  prev_q;
  logic                     first_q;
  logic signed [ALT_W-1:0]  filt_q;
  logic signed [RATE_W-1:0] climb_q;
  logic signed [RATE_W-1:0] vario_q;
  logic signed [RATE_W-1:0] held_q;
  logic                     upd_q;

  logic signed [DIV_W-1:0] acc_q;
  logic [CNT_W-1:0]        idx_q;
  logic                    div_go_q;
  logic [DVS_W-1:0]        dvs_q;

  logic                     out_valid_q;
  logic signed [ALT_W-1:0]  out_filt_q;
  logic signed [RATE_W-1:0] out_climb_q;
  logic signed [RATE_W-1:0] out_vario_q;
  logic signed [RATE_W-1:0] out_avg_q;
  logic                     out_upd_q;

  avf_div_req_t div_req;
  avf_div_rsp_t div_rsp;

  logic [SENS_W-1:0]       sens_eff;
  logic [CNT_W-1:0]        vn_raw, vn, ln_raw, ln, limit;
  logic [CNT_W-1:0]        vnext, snext, lnext;
  logic signed [ALT_W-1:0] elem;
  logic signed [ALT_W-1:0] prev_use;
  logic signed [ALT_W:0]   diff;
  logic signed [DIV_W-1:0] scaled;
  logic signed [RATE_W-1:0] climb_c;
  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    div_wait;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_DONE) && out_free;
  assign div_wait = (state_q == S_ALT_DIV) || (state_q == S_VAR_DIV) ||
                    (state_q == S_SEC_DIV) || (state_q == S_LONG_DIV);

  always_comb begin
    sens_eff = (sens_q == '0) ? SENS_W'(1) : sens_q;
    vn_raw   = {sens_eff, 2'b00};
    vn       = (vn_raw > CNT_W'(VARIO_SLOTS)) ? CNT_W'(VARIO_SLOTS) : vn_raw;
    ln_raw   = {span_q, 3'b000} + {2'b00, span_q, 1'b0};
    ln       = (ln_raw > CNT_W'(LONG_SLOTS)) ? CNT_W'(LONG_SLOTS) : ln_raw;

    vnext = CNT_W'(vslot_q) + CNT_W'(1);
    snext = CNT_W'(sslot_q) + CNT_W'(1);
    lnext = CNT_W'(lslot_q) + CNT_W'(1);

    unique case (state_q)
      S_ALT_SUM: begin
        limit = CNT_W'(ALT_TAPS);
        elem  = win_q[idx_q[AW-1:0]];
      end
      S_VAR_SUM: begin
        limit = vn;
        elem  = ALT_W'(vring_q[idx_q[VW-1:0]]);
      end
      S_SEC_SUM: begin
        limit = CNT_W'(SAMPLES_PER_SECOND);
        elem  = ALT_W'(sring_q[idx_q[SW-1:0]]);
      end
      S_LONG_SUM: begin
        limit = ln;
        elem  = ALT_W'(lring_q[idx_q[LW-1:0]]);
      end
      default: begin
        limit = CNT_W'(1);
        elem  = '0;
      end
    endcase

    // climb = 8 * change of the filtered altitude, saturated
    prev_use = first_q ? raw_q : prev_q;
    diff     = $signed({filt_q[ALT_W-1], filt_q}) -
               $signed({prev_use[ALT_W-1], prev_use});
    scaled   = DIV_W'(diff) <<< 3;
    if (scaled > SAT_HI) begin
      climb_c = RATE_W'(32767);
    end else if (scaled < SAT_LO) begin
      climb_c = -RATE_W'(32768);
    end else begin
      climb_c = scaled[RATE_W-1:0];
    end
  end

  always_comb begin
    div_req.start    = div_go_q;
    div_req.dividend = acc_q;
    div_req.divisor  = dvs_q;
  end

  avf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sens_q      <= SENS_RST;
      span_q      <= SPAN_RST;
      win_q       <= '{default: '0};
      vring_q     <= '{default: '0};
      sring_q     <= '{default: '0};
      lring_q     <= '{default: '0};
      vslot_q     <= '0;
      sslot_q     <= '0;
      lslot_q     <= '0;
      raw_q       <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      filt_q      <= '0;
      climb_q     <= '0;
      vario_q     <= '0;
      held_q      <= '0;
      upd_q       <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      div_go_q    <= 1'b0;
      dvs_q       <= '0;
      out_valid_q <= 1'b0;
      out_filt_q  <= '0;
      out_climb_q <= '0;
      out_vario_q <= '0;
      out_avg_q   <= '0;
      out_upd_q   <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VARIO_SENS: sens_q <= cfg_data_i;
          CFG_CLIMB_SPAN: span_q <= cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            win_q[0] <= altitude_cm_i;
            for (int i = 1; i < ALT_TAPS; i++) begin
              win_q[i] <= win_q[i-1];
            end
            raw_q   <= altitude_cm_i;
            upd_q   <= 1'b0;
            acc_q   <= '0;
            idx_q   <= '0;
            state_q <= S_ALT_SUM;
          end
        end

        S_ALT_SUM, S_VAR_SUM, S_SEC_SUM, S_LONG_SUM: begin
          acc_q <= acc_q + DIV_W'(elem);
          idx_q <= idx_q + CNT_W'(1);
          if (idx_q == limit - CNT_W'(1)) begin
            div_go_q <= 1'b1;
            dvs_q    <= limit;
            priority case (state_q)
              S_ALT_SUM: state_q <= S_ALT_DIV;
              S_VAR_SUM: state_q <= S_VAR_DIV;
              S_SEC_SUM: state_q <= S_SEC_DIV;
              default:   state_q <= S_LONG_DIV;
            endcase
          end
        end

        S_ALT_DIV: begin
          if (div_rsp.done) begin
            filt_q  <= div_rsp.quotient[ALT_W-1:0];
            state_q <= S_CLIMB;
          end
        end

        S_CLIMB: begin
          climb_q <= climb_c;
          prev_q  <= filt_q;
          first_q <= 1'b0;
          if (vnext >= vn) begin
            vslot_q    <= '0;
            vring_q[0] <= climb_c;
          end else begin
            vslot_q                  <= vnext[VW-1:0];
            vring_q[vnext[VW-1:0]]   <= climb_c;
          end
          if (span_q != '0) begin
            if (snext >= CNT_W'(SAMPLES_PER_SECOND)) begin
              sslot_q    <= '0;
              sring_q[0] <= climb_c;
            end else begin
              sslot_q                <= snext[SW-1:0];
              sring_q[snext[SW-1:0]] <= climb_c;
            end
          end
          acc_q   <= '0;
          idx_q   <= '0;
          state_q <= S_VAR_SUM;
        end

        S_VAR_DIV: begin
          if (div_rsp.done) begin
            vario_q <= div_rsp.quotient[RATE_W-1:0];
            acc_q   <= '0;
            idx_q   <= '0;
            if (span_q == '0) begin
              held_q  <= div_rsp.quotient[RATE_W-1:0];
              state_q <= S_DONE;
            end else if (sslot_q == '0) begin
              state_q <= S_SEC_SUM;
            end else begin
              state_q <= S_DONE;
            end
          end
        end

        S_SEC_DIV: begin
          if (div_rsp.done) begin
            if (lnext >= ln) begin
              lslot_q    <= '0;
              lring_q[0] <= div_rsp.quotient[RATE_W-1:0];
            end else begin
              lslot_q                <= lnext[LW-1:0];
              lring_q[lnext[LW-1:0]] <= div_rsp.quotient[RATE_W-1:0];
            end
            acc_q   <= '0;
            idx_q   <= '0;
            state_q <= S_LONG_SUM;
          end
        end

        S_LONG_DIV: begin
          if (div_rsp.done) begin
            held_q  <= div_rsp.quotient[RATE_W-1:0];
            upd_q   <= 1'b1;
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_filt_q  <= filt_q;
            out_climb_q <= climb_q;
            out_vario_q <= vario_q;
            out_avg_q   <= held_q;
            out_upd_q   <= upd_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o             = (state_q == S_IDLE);
  assign out_valid_o            = out_valid_q;
  assign filtered_altitude_cm_o = out_filt_q;
  assign instant_climb_o        = out_climb_q;
  assign vario_rate_o           = out_vario_q;
  assign long_climb_o           = out_avg_q;
  assign average_updated_o      = out_upd_q;

  `AVF_ASSERT(a_div_done_in_wait, !div_rsp.done || div_wait, "divider result outside a wait state")
  `AVF_ASSERT(a_vslot_range, vslot_q < VW'(VARIO_SLOTS - 1) || vslot_q == VW'(VARIO_SLOTS - 1), "vario slot past ring")
  `AVF_ASSERT(a_upd_needs_span, !(out_valid_q && out_upd_q) || span_q != '0, "average update with span zero")
  `AVF_ASSERT(a_idle_no_div, state_q != S_IDLE || (!div_go_q && !div_rsp.busy), "divider active while idle")
  `AVF_ASSERT_NEXT(a_accept_busy, accept, !in_ready_o, "ready held after accept")

endmodule

// ----- bench/vario_filter_check.sv -----
// ----------------------------------------------------------------------------
// vario_filter_check
// Watches the altitude and result channels of the vario filter, keeps its own
// copy of the filter state and register settings, and compares every result
// word field by field against the prediction made when its sample went in.
// ----------------------------------------------------------------------------
module vario_filter_check import avf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [ALT_W-1:0] altitude_cm_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [ALT_W-1:0]  filtered_altitude_cm_i,
  input  logic signed [RATE_W-1:0] instant_climb_i,
  input  logic signed [RATE_W-1:0] vario_rate_i,
  input  logic signed [RATE_W-1:0] long_climb_i,
  input  logic                     average_updated_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      error_count_o,
  output int                      readings_due_o,
  output int                      readings_done_o,
  output int                      seconds_closed_o
);

  typedef struct packed {
    logic signed [ALT_W-1:0]  filtered;
    logic signed [RATE_W-1:0] climb;
    logic signed [RATE_W-1:0] vario;
    logic signed [RATE_W-1:0] average;
    logic                     updated;
  } reading_t;

  logic [SENS_W-1:0] sensitivity;
  logic [SPAN_W-1:0] span;

  logic signed [ALT_W-1:0]  alt_window  [DEF_ALT_TAPS];
  logic signed [ALT_W-1:0]  prev_filtered;
  logic                     first_pending;
  logic signed [RATE_W-1:0] vario_ring  [DEF_VARIO_SLOTS];
  int                       vario_slot;
  logic signed [RATE_W-1:0] second_ring [DEF_SAMPLES_PER_SECOND];
  int                       second_slot;
  logic signed [RATE_W-1:0] long_ring   [DEF_LONG_SLOTS];
  int                       long_slot;
  logic signed [RATE_W-1:0] held_average;

  reading_t pending_readings[$];
  reading_t want;
  reading_t fresh;
  int       error_cnt;
  int       done_cnt;
  int       due_cnt;
  int       seconds_cnt;

  assign error_count_o    = error_cnt;
  assign readings_due_o   = due_cnt;
  assign readings_done_o  = done_cnt;
  assign seconds_closed_o = seconds_cnt;

  task automatic clear_state();
    sensitivity   = SENS_RST;
    span          = SPAN_RST;
    prev_filtered = '0;
    first_pending = 1'b1;
    vario_slot    = 0;
    second_slot   = 0;
    long_slot     = 0;
    held_average  = '0;
    foreach (alt_window[i]) alt_window[i] = '0;
    foreach (vario_ring[i]) vario_ring[i] = '0;
    foreach (second_ring[i]) second_ring[i] = '0;
    foreach (long_ring[i]) long_ring[i] = '0;
  endtask

  // one sample through the whole filter; updates the predictor state
  function automatic reading_t filter_altitude(input logic signed [ALT_W-1:0] raw);
    reading_t r;
    longint   acc;
    longint   climb_full;
    int       vn;
    int       ln;
    r = '0;
    for (int i = DEF_ALT_TAPS - 1; i > 0; i--) alt_window[i] = alt_window[i-1];
    alt_window[0] = raw;
    acc = 0;
    for (int i = 0; i < DEF_ALT_TAPS; i++) acc += alt_window[i];
    r.filtered = ALT_W'(acc / DEF_ALT_TAPS);

    if (first_pending) begin
      prev_filtered = raw;
      first_pending = 1'b0;
    end
    climb_full = (longint'(r.filtered) - longint'(prev_filtered)) * 8;
    if (climb_full > 32767) r.climb = 16'sh7fff;
    else if (climb_full < -32768) r.climb = 16'sh8000;
    else r.climb = RATE_W'(climb_full);
    prev_filtered = r.filtered;

    vn = 4 * ((sensitivity == 0) ? 1 : int'(sensitivity));
    if (vn > DEF_VARIO_SLOTS) vn = DEF_VARIO_SLOTS;
    vario_slot++;
    if (vario_slot >= vn) vario_slot = 0;
    vario_ring[vario_slot] = r.climb;
    acc = 0;
    for (int i = 0; i < vn; i++) acc += vario_ring[i];
    r.vario = RATE_W'(acc / vn);

    if (span == 0) begin
      // long average just tracks the vario; second and long rings sit still
      held_average = r.vario;
    end else begin
      second_slot++;
      if (second_slot >= DEF_SAMPLES_PER_SECOND) second_slot = 0;
      second_ring[second_slot] = r.climb;
      if (second_slot == 0) begin
        ln = 10 * int'(span);
        if (ln > DEF_LONG_SLOTS) ln = DEF_LONG_SLOTS;
        long_slot++;
        if (long_slot >= ln) long_slot = 0;
        acc = 0;
        for (int i = 0; i < DEF_SAMPLES_PER_SECOND; i++) acc += second_ring[i];
        long_ring[long_slot] = RATE_W'(acc / DEF_SAMPLES_PER_SECOND);
        acc = 0;
        for (int i = 0; i < ln; i++) acc += long_ring[i];
        held_average = RATE_W'(acc / ln);
        r.updated = 1'b1;
      end
    end
    r.average = held_average;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    error_cnt++;
    $display("MISMATCH word %0d %s: got %0d, want %0d", done_cnt, what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      pending_readings.delete();
      error_cnt   = 0;
      done_cnt    = 0;
      due_cnt     = 0;
      seconds_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result word with nothing pending", filtered_altitude_cm_i, 0);
        end else begin
          want = pending_readings.pop_front();
          if (filtered_altitude_cm_i !== want.filtered)
            report_mismatch("filtered_altitude_cm", filtered_altitude_cm_i, want.filtered);
          if (instant_climb_i !== want.climb)
            report_mismatch("instant_climb", instant_climb_i, want.climb);
          if (vario_rate_i !== want.vario)
            report_mismatch("vario_rate", vario_rate_i, want.vario);
          if (long_climb_i !== want.average)
            report_mismatch("long_climb", long_climb_i, want.average);
          if (average_updated_i !== want.updated)
            report_mismatch("average_updated", average_updated_i, want.updated);
          done_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = filter_altitude(altitude_cm_i);
        pending_readings.push_back(fresh);
        if (fresh.updated) seconds_cnt++;
      end
      due_cnt = pending_readings.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VARIO_SENS: sensitivity = cfg_data_i[SENS_W-1:0];
          CFG_CLIMB_SPAN: span = cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the altitude vario filter unit. A short directed
// flight hits the altitude extremes, first-sample preset, saturation and the
// register corner settings; then random flight phases (mostly drifting random
// walks with spikes and jumps) run under a range of filter settings with
// random stalls on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb;
  import avf_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 250;   // beyond the slowest one-second word
  localparam int RANDOM_PHASES   = 10;

  localparam int ALT_MAX   = (1 <<< (ALT_W - 1)) - 1;
  localparam int ALT_MIN   = -(1 <<< (ALT_W - 1));
  localparam int ALT_FLOOR = -1000000;
  localparam int ALT_CEIL  = 4000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [ALT_W-1:0] altitude_cm_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [ALT_W-1:0]  filtered_altitude_cm_o;
  logic signed [RATE_W-1:0] instant_climb_o;
  logic signed [RATE_W-1:0] vario_rate_o;
  logic signed [RATE_W-1:0] long_climb_o;
  logic                     average_updated_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  int error_count;
  int readings_due;
  int readings_done;
  int seconds_closed;
  int cycle_count = 0;
  int settings_used = 0;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_request = 1'b0;
  int altitude_now = 150000;
  int drift = 0;

  // directed flight: first sample, extremes, saturating jumps, then a climb
  int flight_a [16] = '{123456, 4194303, -4194304, 0, 0, 4000000, -1000000, -1,
                        150000, 150000, 150010, 150030, 150060, 150100, 150150,
                        150210};
  int flight_b [4]  = '{150280, 150350, 150300, 150200};
  int flight_c [8]  = '{150000, 149900, 149800, 149700, 149600, 149500, 149400,
                        149300};

  logic [SENS_W-1:0] sens_table [5] = '{3'd1, 3'd6, 3'd2, 3'd0, 3'd7};
  logic [SPAN_W-1:0] span_table [5] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

  always #1 clk_i = ~clk_i;

  altitude_vario_filter_unit dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .altitude_cm_i          (altitude_cm_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .filtered_altitude_cm_o (filtered_altitude_cm_o),
    .instant_climb_o        (instant_climb_o),
    .vario_rate_o           (vario_rate_o),
    .long_climb_o           (long_climb_o),
    .average_updated_o      (average_updated_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i)
  );

  vario_filter_check check (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_i             (in_ready_o),
    .altitude_cm_i          (altitude_cm_i),
    .out_valid_i            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .filtered_altitude_cm_i (filtered_altitude_cm_o),
    .instant_climb_i        (instant_climb_o),
    .vario_rate_i           (vario_rate_o),
    .long_climb_i           (long_climb_o),
    .average_updated_i      (average_updated_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .error_count_o          (error_count),
    .readings_due_o         (readings_due),
    .readings_done_o        (readings_done),
    .seconds_closed_o       (seconds_closed)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, readings_due);
      $display("Some tests failed");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays up when the gap is zero
  task automatic send_word(input int alt);
    int gap;
    gap = tx_eager ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    altitude_cm_i <= ALT_W'(alt);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (readings_due != 0);
  endtask

  // both registers in back-to-back cycles; the spare data bit of span is noise
  task automatic set_filter(input logic [SENS_W-1:0] sens, input logic [SPAN_W-1:0] spn);
    wait_drained();
    repeat (8) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VARIO_SENS;
    cfg_data_i <= sens;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_CLIMB_SPAN;
    cfg_data_i <= {1'($urandom_range(0, 1)), spn};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  function automatic int next_altitude();
    int                      pick;
    logic signed [ALT_W-1:0] raw_bits;
    pick = int'($urandom_range(0, 99));
    if (pick < 78) begin
      altitude_now += drift + int'($urandom_range(0, 400)) - 200;
      if (altitude_now > ALT_CEIL) altitude_now = ALT_CEIL;
      if (altitude_now < ALT_FLOOR) altitude_now = ALT_FLOOR;
    end else if (pick < 86) begin
      raw_bits = ALT_W'($urandom);
      return raw_bits;
    end else if (pick < 92) begin
      case ($urandom_range(0, 5))
        0: return ALT_MAX;
        1: return ALT_MIN;
        2: return ALT_CEIL;
        3: return ALT_FLOOR;
        4: return 0;
        default: return -1;
      endcase
    end else begin
      altitude_now = int'($urandom_range(0, ALT_CEIL - ALT_FLOOR)) + ALT_FLOOR;
    end
    return altitude_now;
  endfunction

  // result side: random stall per word, plus one long hold-off on request
  initial begin : result_side
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      stall = rx_eager ? 0 : int'($urandom_range(0, 7));
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : sample_side
    int len;
    logic [SENS_W-1:0] sens;
    logic [SPAN_W-1:0] spn;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults first, then the zero and oversized settings
    foreach (flight_a[i]) send_word(flight_a[i]);
    set_filter(3'd0, 2'd0);
    foreach (flight_b[i]) send_word(flight_b[i]);
    set_filter(3'd7, 2'd3);
    foreach (flight_c[i]) send_word(flight_c[i]);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 5) begin
        sens = sens_table[p];
        spn  = span_table[p];
      end else begin
        sens = SENS_W'($urandom_range(0, 7));
        spn  = SPAN_W'($urandom_range(0, 3));
      end
      set_filter(sens, spn);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      drift    = int'($urandom_range(0, 120)) - 60;
      len      = int'($urandom_range(70, 130));
      // receiver sits still while samples keep coming; input must back up
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (p == 4 && i == len / 2) wait_drained();
        send_word(next_altitude());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d filtered samples with %0d one-second updates under %0d settings",
             readings_done, seconds_closed, settings_used);
    if (error_count == 0 && readings_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d words never delivered", error_count, readings_due);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
